### design/pws_pkg.sv
// Shared types, constants and a helper function for the PWM window scanner.
package pws_pkg;

	localparam int MAX_MOTIF_DEF   = 32;
	localparam int MAX_SEQ_LEN_DEF = 4096;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int MOTIF_W    = 6;
	localparam int SCORE_W    = 21;
	localparam int CFG_DATA_W = 21;
	localparam int CFG_IDX_W  = 1;
	localparam int SYM_W      = 8;
	localparam int SEQ_ID_W   = 3;
	localparam int WBASE_W    = 2;
	localparam int WCOL_W     = 5;
	localparam int WVAL_W     = 16;
	localparam int POS_W      = 12;

	localparam logic [MOTIF_W-1:0] MOTIF_RST     = MOTIF_W'(8);
	localparam logic [SCORE_W-1:0] THRESHOLD_RST = SCORE_W'(1536);

	localparam int SCORE_MAX = 1048575;
	localparam int SCORE_MIN = -1048576;

	localparam logic [SYM_W-1:0] SYM_A = SYM_W'("A");
	localparam logic [SYM_W-1:0] SYM_C = SYM_W'("C");
	localparam logic [SYM_W-1:0] SYM_G = SYM_W'("G");
	localparam logic [SYM_W-1:0] SYM_T = SYM_W'("T");

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_SCAN = 1'b1
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOTIF_LENGTH    = 1'b0,
		CFG_SCORE_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CODE_A     = 3'd0,
		CODE_C     = 3'd1,
		CODE_G     = 3'd2,
		CODE_T     = 3'd3,
		CODE_OTHER = 3'd4
	} base_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic issue;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic score_go;
		logic last_col;
		logic hit;
		logic out_free;
	} dp_stat_t;

	function automatic base_code_t base_code(input logic [SYM_W-1:0] sym);
		base_code_t code;
		case (sym)
			SYM_A:   code = CODE_A;
			SYM_C:   code = CODE_C;
			SYM_G:   code = CODE_G;
			SYM_T:   code = CODE_T;
			default: code = CODE_OTHER;
		endcase
		return code;
	endfunction

endpackage

### design/pws_ctrl.sv
// Controller state machine: transaction acceptance and window scoring sequence.
module pws_ctrl import pws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     req_type,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.scan = 1'b1;
						if (stat.score_go) begin
							state_d = S_ISSUE;
						end
					end
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				if (stat.last_col) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINAL;
			end
			S_FINAL: begin
				if (!stat.hit) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### design/pws_datapath.sv
// Datapath: configuration, weight table, base window, score accumulator, hit register.
module pws_datapath import pws_pkg::*; #(
	parameter int MAX_MOTIF   = MAX_MOTIF_DEF,
	parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [SYM_W-1:0]           symbol,
	input  logic                       sequence_start,
	input  logic [SEQ_ID_W-1:0]        sequence_id,
	input  logic [WBASE_W-1:0]         weight_base,
	input  logic [WCOL_W-1:0]          weight_column,
	input  logic signed [WVAL_W-1:0]   weight_value,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [SEQ_ID_W-1:0]        hit_sequence,
	output logic [POS_W-1:0]           hit_position,
	output logic signed [SCORE_W-1:0]  hit_score
);

	localparam int COL_W     = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;
	localparam int LEN_W     = $clog2(MAX_MOTIF + 1);
	localparam int IDX_W     = LEN_W + 1;
	localparam int SEQ_W     = $clog2(MAX_SEQ_LEN);
	localparam int CNT_W     = ((SEQ_W > LEN_W) ? SEQ_W : LEN_W) + 1;
	localparam int TBL_AW    = COL_W + WBASE_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;
	localparam int ACC_W     = WEIGHT_BITS + COL_W + 1;
	localparam int SAT_W     = ((ACC_W > SCORE_W) ? ACC_W : SCORE_W) + 1;
	localparam int WEXT_W    = (WEIGHT_BITS > WVAL_W) ? WEIGHT_BITS : WVAL_W;
	localparam int WCX_W     = ((COL_W > WCOL_W) ? COL_W : WCOL_W) + 1;
	localparam longint WMAX  = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
	localparam longint WMIN  = -WMAX - 1;

	localparam logic signed [WEXT_W-1:0] W_HI   = WEXT_W'(WMAX);
	localparam logic signed [WEXT_W-1:0] W_LO   = WEXT_W'(WMIN);
	localparam logic signed [SAT_W-1:0]  SAT_HI = SAT_W'(SCORE_MAX);
	localparam logic signed [SAT_W-1:0]  SAT_LO = SAT_W'(SCORE_MIN);

	logic [MOTIF_W-1:0]         motif_q;
	logic signed [SCORE_W-1:0]  thr_q;
	base_code_t                 win_q [MAX_MOTIF];
	logic [SEQ_W-1:0]           chars_q;
	logic [SEQ_ID_W-1:0]        seq_q;
	logic [WEIGHT_BITS-1:0]     tbl_mem [TBL_DEPTH];
	logic [WEIGHT_BITS-1:0]     rd_data_s1;
	logic                       rd_base_s1;
	logic                       rd_valid_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic [LEN_W-1:0]           col_q;
	logic                       out_valid_q;
	logic [SEQ_ID_W-1:0]        hit_seq_q;
	logic [POS_W-1:0]           hit_pos_q;
	logic signed [SCORE_W-1:0]  hit_score_q;

	logic [LEN_W-1:0]           len;
	logic [SEQ_W-1:0]           cnt0;
	logic [SEQ_W-1:0]           cnt_inc;
	logic                       ovf;
	base_code_t                 code_in;
	logic [IDX_W-1:0]           win_idx;
	base_code_t                 rd_code;
	logic [TBL_AW-1:0]          rd_addr;
	logic [WCX_W-1:0]           wc_ext;
	logic                       wc_ok;
	logic [TBL_AW-1:0]          ld_addr;
	logic signed [WEXT_W-1:0]   wv_ext;
	logic [WEIGHT_BITS-1:0]     wsat;
	logic signed [SAT_W-1:0]    acc_ext;
	logic signed [SCORE_W-1:0]  score;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_q <= MOTIF_RST;
			thr_q   <= THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MOTIF_LENGTH:    motif_q <= cfg_data[MOTIF_W-1:0];
				CFG_SCORE_THRESHOLD: thr_q   <= cfg_data[SCORE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (motif_q == '0) begin
			len = LEN_W'(1);
		end else if ({1'b0, motif_q} > (MOTIF_W + 1)'(MAX_MOTIF)) begin
			len = LEN_W'(MAX_MOTIF);
		end else begin
			len = LEN_W'(motif_q);
		end
	end

	assign cnt0          = sequence_start ? '0 : chars_q;
	assign ovf           = cnt0 >= SEQ_W'(MAX_SEQ_LEN - 1);
	assign cnt_inc       = cnt0 + SEQ_W'(1);
	assign code_in       = base_code(symbol);
	assign stat.score_go = !ovf && (CNT_W'(cnt_inc) >= CNT_W'(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_MOTIF; i++) begin
				win_q[i] <= CODE_OTHER;
			end
			chars_q <= '0;
			seq_q   <= '0;
		end else if (cmd.scan) begin
			if (sequence_start) begin
				seq_q <= sequence_id;
			end
			if (!ovf) begin
				chars_q <= cnt_inc;
				for (int i = 0; i < MAX_MOTIF - 1; i++) begin
					win_q[i] <= sequence_start ? CODE_OTHER : win_q[i + 1];
				end
				win_q[MAX_MOTIF - 1] <= code_in;
			end else begin
				chars_q <= cnt0;
				if (sequence_start) begin
					for (int i = 0; i < MAX_MOTIF; i++) begin
						win_q[i] <= CODE_OTHER;
					end
				end
			end
		end
	end

	assign win_idx       = IDX_W'(MAX_MOTIF) - IDX_W'(len) + IDX_W'(col_q);
	assign rd_code       = win_q[win_idx[COL_W-1:0]];
	assign rd_addr       = {rd_code[WBASE_W-1:0], col_q[COL_W-1:0]};
	assign stat.last_col = col_q == (len - LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.scan) begin
				col_q <= '0;
			end else if (cmd.issue) begin
				col_q <= col_q + LEN_W'(1);
			end
		end
	end

	assign wc_ext  = WCX_W'(weight_column);
	assign wc_ok   = wc_ext < WCX_W'(MAX_MOTIF);
	assign ld_addr = {weight_base, wc_ext[COL_W-1:0]};
	assign wv_ext  = WEXT_W'(weight_value);

	always_comb begin
		if (wv_ext > W_HI) begin
			wsat = WEIGHT_BITS'(W_HI);
		end else if (wv_ext < W_LO) begin
			wsat = WEIGHT_BITS'(W_LO);
		end else begin
			wsat = WEIGHT_BITS'(wv_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wc_ok) begin
			tbl_mem[ld_addr] <= wsat;
		end
		if (cmd.issue) begin
			rd_data_s1 <= tbl_mem[rd_addr];
			rd_base_s1 <= rd_code != CODE_OTHER;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			acc_q <= '0;
		end else if (rd_valid_s1 && rd_base_s1) begin
			acc_q <= acc_q + ACC_W'($signed(rd_data_s1));
		end
	end

	assign acc_ext = SAT_W'(acc_q);

	always_comb begin
		if (acc_ext > SAT_HI) begin
			score = SCORE_W'(SAT_HI);
		end else if (acc_ext < SAT_LO) begin
			score = SCORE_W'(SAT_LO);
		end else begin
			score = SCORE_W'(acc_ext);
		end
	end

	assign stat.hit      = score >= thr_q;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hit_seq_q   <= seq_q;
			hit_pos_q   <= POS_W'(chars_q - SEQ_W'(len));
			hit_score_q <= score;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_sequence = hit_seq_q;
	assign hit_position = hit_pos_q;
	assign hit_score    = hit_score_q;

endmodule

### design/pwm_window_scanner_unit.sv
// Top level of the position weight matrix window scanner.
// A load transaction writes one weight; a scan transaction whose window is not yet full,
// or whose sequence is over length, is accepted without scoring. A scan that completes a
// window is scored over the window length, that is motif_length held to 1..MAX_MOTIF: the
// weight table has a single read port, so the window is scored one column per cycle,
// followed by a drain state for the registered read and a final state that saturates,
// compares and loads the hit register. A hit waits in that register while further
// transactions are accepted; a second hit stalls scoring only until the first is taken.
// Configuration writes are accepted in any cycle.
module pwm_window_scanner_unit import pws_pkg::*; #(
	parameter int MAX_MOTIF   = MAX_MOTIF_DEF,
	parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [SYM_W-1:0]           symbol,
	input  logic                       sequence_start,
	input  logic [SEQ_ID_W-1:0]        sequence_id,
	input  logic [WBASE_W-1:0]         weight_base,
	input  logic [WCOL_W-1:0]          weight_column,
	input  logic signed [WVAL_W-1:0]   weight_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SEQ_ID_W-1:0]        hit_sequence,
	output logic [POS_W-1:0]           hit_position,
	output logic signed [SCORE_W-1:0]  hit_score
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	pws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	pws_datapath #(
		.MAX_MOTIF   (MAX_MOTIF),
		.MAX_SEQ_LEN (MAX_SEQ_LEN),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.symbol         (symbol),
		.sequence_start (sequence_start),
		.sequence_id    (sequence_id),
		.weight_base    (weight_base),
		.weight_column  (weight_column),
		.weight_value   (weight_value),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.hit_sequence   (hit_sequence),
		.hit_position   (hit_position),
		.hit_score      (hit_score)
	);

endmodule

### tb/pwm_window_scanner_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PWM window scanner: weight loads, window scans and hits.
module pwm_window_scanner_unit_tb;
	import pws_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = MAX_MOTIF_DEF + 8;
	localparam int PHASE_ITEMS   = 215;
	localparam int TAIL_ITEMS    = 60;
	localparam logic [SYM_W-1:0] SYM_N = 8'h4E;
	localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;

	typedef struct {
		req_type_t                   kind;
		logic [SYM_W-1:0]            sym;
		logic                        start;
		logic [SEQ_ID_W-1:0]         id;
		logic [WBASE_W-1:0]          wbase;
		logic [WCOL_W-1:0]           wcol;
		logic signed [WVAL_W-1:0]    wval;
	} stream_item_t;

	typedef struct packed {
		logic [SEQ_ID_W-1:0]         seq;
		logic [POS_W-1:0]            pos;
		logic signed [SCORE_W-1:0]   score;
	} hit_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CONFIG
	} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		stream_item_t                it;
		bit                          typed;
		bit                          typed_hit;
		hit_t                        exp_hit;
		logic [MOTIF_W-1:0]          motif;
		logic signed [SCORE_W-1:0]   thr;
	} row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_MOTIF_LENGTH;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        req_type = REQ_LOAD;
	logic [SYM_W-1:0]            symbol = '0;
	logic                        sequence_start = 1'b0;
	logic [SEQ_ID_W-1:0]         sequence_id = '0;
	logic [WBASE_W-1:0]          weight_base = '0;
	logic [WCOL_W-1:0]           weight_column = '0;
	logic signed [WVAL_W-1:0]    weight_value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b1;
	logic [SEQ_ID_W-1:0]         hit_sequence;
	logic [POS_W-1:0]            hit_position;
	logic signed [SCORE_W-1:0]   hit_score;

	logic signed [WVAL_W-1:0]    weights [4*MAX_MOTIF_DEF];
	base_code_t                  win [MAX_MOTIF_DEF];
	int                          seen;
	logic [SEQ_ID_W-1:0]         cur_seq;
	logic [MOTIF_W-1:0]          motif_reg;
	logic signed [SCORE_W-1:0]   thr_reg;

	hit_t                        pending_hits [$];
	int                          mismatches = 0;
	int                          in_idle_pct = 0;
	int                          out_idle_pct = 0;
	int                          out_hold = 0;
	int                          quiet_cycles = 0;

	pwm_window_scanner_unit dut (.*);

	always #CLK_HALF clk = ~clk;

	function automatic bit apply_item(input stream_item_t it, output hit_t h);
		int len;
		int i;
		longint sum;
		base_code_t c;
		h = '0;
		if (it.kind == REQ_LOAD) begin
			weights[{it.wbase, it.wcol}] = it.wval;
			return 1'b0;
		end
		if (it.start) begin
			foreach (win[k]) win[k] = CODE_OTHER;
			seen = 0;
			cur_seq = it.id;
		end
		if (seen >= MAX_SEQ_LEN_DEF - 1)
			return 1'b0;
		case (it.sym)
			SYM_A:   c = CODE_A;
			SYM_C:   c = CODE_C;
			SYM_G:   c = CODE_G;
			SYM_T:   c = CODE_T;
			default: c = CODE_OTHER;
		endcase
		for (i = 0; i < MAX_MOTIF_DEF - 1; i++)
			win[i] = win[i + 1];
		win[MAX_MOTIF_DEF - 1] = c;
		seen++;
		len = (motif_reg == 0) ? 1 : ((motif_reg > MAX_MOTIF_DEF) ? MAX_MOTIF_DEF : motif_reg);
		if (seen < len)
			return 1'b0;
		sum = 0;
		for (i = 0; i < len; i++) begin
			c = win[MAX_MOTIF_DEF - len + i];
			if (c != CODE_OTHER)
				sum += weights[int'(c) * MAX_MOTIF_DEF + i];
		end
		if (sum > SCORE_MAX)
			sum = SCORE_MAX;
		if (sum < SCORE_MIN)
			sum = SCORE_MIN;
		if (sum < thr_reg)
			return 1'b0;
		h.seq = cur_seq;
		h.pos = POS_W'(seen - len);
		h.score = SCORE_W'(sum);
		return 1'b1;
	endfunction

	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(0, 19);
		if (r < 4)
			return SYM_A;
		if (r < 8)
			return SYM_C;
		if (r < 12)
			return SYM_G;
		if (r < 16)
			return SYM_T;
		return SYM_W'($urandom);
	endfunction

	function automatic logic signed [SCORE_W-1:0] rand_thr();
		int v;
		if ($urandom_range(0, 3) == 0)
			return SCORE_W'($urandom);
		v = $urandom_range(0, 120000);
		v -= 60000;
		return SCORE_W'(v);
	endfunction

	function automatic stream_item_t scan_of(input logic [SYM_W-1:0] s, input logic st,
			input logic [SEQ_ID_W-1:0] id);
		stream_item_t it;
		it.kind = REQ_SCAN;
		it.sym = s;
		it.start = st;
		it.id = id;
		it.wbase = WBASE_W'($urandom);
		it.wcol = WCOL_W'($urandom);
		it.wval = WVAL_W'($urandom);
		return it;
	endfunction

	function automatic stream_item_t load_of(input logic [WBASE_W-1:0] b,
			input logic [WCOL_W-1:0] c, input logic signed [WVAL_W-1:0] v);
		stream_item_t it;
		it.kind = REQ_LOAD;
		it.sym = SYM_W'($urandom);
		it.start = 1'($urandom);
		it.id = SEQ_ID_W'($urandom);
		it.wbase = b;
		it.wcol = c;
		it.wval = v;
		return it;
	endfunction

	function automatic row_t load_row(input logic [WBASE_W-1:0] b, input logic [WCOL_W-1:0] c,
			input logic signed [WVAL_W-1:0] v);
		row_t r;
		r.kind = ROW_ITEM;
		r.it = load_of(b, c, v);
		r.typed = 1'b1;
		r.typed_hit = 1'b0;
		r.exp_hit = '0;
		return r;
	endfunction

	function automatic row_t scan_row(input logic [SYM_W-1:0] s, input logic st,
			input logic [SEQ_ID_W-1:0] id);
		row_t r;
		r.kind = ROW_ITEM;
		r.it = scan_of(s, st, id);
		r.typed = 1'b0;
		r.typed_hit = 1'b0;
		r.exp_hit = '0;
		return r;
	endfunction

	function automatic row_t quiet_row(input logic [SYM_W-1:0] s, input logic st,
			input logic [SEQ_ID_W-1:0] id);
		row_t r;
		r = scan_row(s, st, id);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic row_t hit_row(input logic [SYM_W-1:0] s, input logic st,
			input logic [SEQ_ID_W-1:0] id, input logic [SEQ_ID_W-1:0] q,
			input logic [POS_W-1:0] p, input logic signed [SCORE_W-1:0] sc);
		row_t r;
		r = scan_row(s, st, id);
		r.typed = 1'b1;
		r.typed_hit = 1'b1;
		r.exp_hit.seq = q;
		r.exp_hit.pos = p;
		r.exp_hit.score = sc;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [MOTIF_W-1:0] m,
			input logic signed [SCORE_W-1:0] t);
		row_t r;
		r.kind = ROW_CONFIG;
		r.typed = 1'b0;
		r.typed_hit = 1'b0;
		r.exp_hit = '0;
		r.motif = m;
		r.thr = t;
		return r;
	endfunction

	task automatic send(input stream_item_t it, input bit typed, input bit typed_hit,
			input hit_t typed_val);
		hit_t h;
		bit got;
		if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.kind;
		symbol <= it.sym;
		sequence_start <= it.start;
		sequence_id <= it.id;
		weight_base <= it.wbase;
		weight_column <= it.wcol;
		weight_value <= it.wval;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		got = apply_item(it, h);
		if (typed) begin
			got = typed_hit;
			h = typed_val;
		end
		if (got)
			pending_hits.push_back(h);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [MOTIF_W-1:0] m, input logic signed [SCORE_W-1:0] t);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[MOTIF_W-1:0] = m;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MOTIF_LENGTH;
		cfg_data <= d;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		motif_reg = d[MOTIF_W-1:0];
		cfg_index <= CFG_SCORE_THRESHOLD;
		cfg_data <= t;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		thr_reg = t;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
		end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
			out_ready <= 1'b0;
			out_hold <= $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected hit: seq %0d pos %0d score %0d",
						hit_sequence, hit_position, hit_score);
			end else begin
				want = pending_hits.pop_front();
				if (hit_sequence !== want.seq || hit_position !== want.pos ||
						hit_score !== want.score) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: exp seq %0d pos %0d score %0d, got %0d %0d %0d",
							want.seq, want.pos, want.score,
							hit_sequence, hit_position, hit_score);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("pwm_window_scanner_unit_tb failed");
			$finish;
		end
	end

	initial begin
		row_t plan [$];
		stream_item_t it;
		hit_t no_hit;
		logic [MOTIF_W-1:0] m;
		logic signed [SCORE_W-1:0] t;
		logic [SEQ_ID_W-1:0] sid;
		int p;
		int n;
		int r;
		int seq_left;

		no_hit = '0;
		foreach (weights[k]) weights[k] = '0;
		foreach (win[k]) win[k] = CODE_OTHER;
		seen = 0;
		cur_seq = '0;
		motif_reg = MOTIF_RST;
		thr_reg = THRESHOLD_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 20;
		out_idle_pct = 20;
		repeat (3) send(scan_of(pick_symbol(), 1'b0, SEQ_ID_W'($urandom)), 1'b0, 1'b0, no_hit);
		for (n = 0; n < 4 * MAX_MOTIF_DEF; n++)
			send(load_of(WBASE_W'(n / MAX_MOTIF_DEF), WCOL_W'(n), WVAL_W'($urandom)),
				1'b0, 1'b0, no_hit);
		repeat (5) send(scan_of(pick_symbol(), 1'b0, SEQ_ID_W'($urandom)), 1'b0, 1'b0, no_hit);

		plan.push_back(cfg_row(6'd0, SCORE_W'(SCORE_MIN)));
		plan.push_back(load_row(WBASE_W'(CODE_A), 5'd0, 16'sh7FFF));
		plan.push_back(load_row(WBASE_W'(CODE_C), 5'd0, 16'sh8000));
		plan.push_back(load_row(WBASE_W'(CODE_G), 5'd0, 16'sd256));
		plan.push_back(load_row(WBASE_W'(CODE_T), 5'd0, -16'sd1));
		plan.push_back(hit_row(SYM_A, 1'b1, 3'd7, 3'd7, 12'd0, 21'sd32767));
		plan.push_back(hit_row(SYM_C, 1'b0, 3'd1, 3'd7, 12'd1, -21'sd32768));
		plan.push_back(hit_row(SYM_G, 1'b0, 3'd2, 3'd7, 12'd2, 21'sd256));
		plan.push_back(hit_row(SYM_T, 1'b0, 3'd3, 3'd7, 12'd3, -21'sd1));
		plan.push_back(hit_row(SYM_N, 1'b0, 3'd4, 3'd7, 12'd4, 21'sd0));
		plan.push_back(hit_row(SYM_LOWER_A, 1'b0, 3'd5, 3'd7, 12'd5, 21'sd0));
		plan.push_back(hit_row(8'hFF, 1'b0, 3'd6, 3'd7, 12'd6, 21'sd0));
		plan.push_back(hit_row(8'h00, 1'b0, 3'd0, 3'd7, 12'd7, 21'sd0));
		plan.push_back(hit_row(SYM_A, 1'b0, 3'd2, 3'd7, 12'd8, 21'sd32767));
		plan.push_back(hit_row(SYM_C, 1'b1, 3'd0, 3'd0, 12'd0, -21'sd32768));
		plan.push_back(cfg_row(6'd0, 21'sd0));
		plan.push_back(quiet_row(SYM_C, 1'b0, 3'd5));
		plan.push_back(hit_row(SYM_G, 1'b1, 3'd3, 3'd3, 12'd0, 21'sd256));
		plan.push_back(cfg_row(6'd2, 21'sd0));
		plan.push_back(scan_row(SYM_T, 1'b0, 3'd6));
		plan.push_back(cfg_row(6'd2, SCORE_W'(SCORE_MAX)));
		plan.push_back(quiet_row(SYM_A, 1'b0, 3'd1));
		plan.push_back(cfg_row(6'd63, SCORE_W'(SCORE_MIN)));
		plan.push_back(scan_row(SYM_A, 1'b1, 3'd6));
		plan.push_back(scan_row(SYM_G, 1'b0, 3'd4));

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CONFIG) begin
				settle();
				write_regs(plan[k].motif, plan[k].thr);
			end else begin
				send(plan[k].it, plan[k].typed, plan[k].typed_hit, plan[k].exp_hit);
			end
		end

		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: begin
					m = 6'd1;
					t = SCORE_W'(SCORE_MIN);
				end
				1: begin
					m = 6'd32;
					t = rand_thr();
				end
				2: begin
					m = 6'd0;
					t = SCORE_W'(SCORE_MAX);
				end
				3: begin
					m = MOTIF_W'($urandom_range(33, 63));
					t = rand_thr();
				end
				default: begin
					m = MOTIF_W'($urandom_range(1, 12));
					t = rand_thr();
				end
			endcase
			write_regs(m, t);
			in_idle_pct = (p == 4) ? 0 : $urandom_range(5, 40);
			out_idle_pct = (p == 4) ? 0 : $urandom_range(5, 40);
			seq_left = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					it = load_of(WBASE_W'($urandom), WCOL_W'($urandom), WVAL_W'($urandom));
				end else if (r < 12) begin
					it.kind = req_type_t'($urandom_range(0, 1));
					it.sym = SYM_W'($urandom);
					it.start = 1'($urandom);
					it.id = SEQ_ID_W'($urandom);
					it.wbase = WBASE_W'($urandom);
					it.wcol = WCOL_W'($urandom);
					it.wval = WVAL_W'($urandom);
				end else begin
					it = scan_of(pick_symbol(), seq_left == 0, SEQ_ID_W'($urandom));
					if (seq_left == 0)
						seq_left = $urandom_range(1, (m > 12) ? 100 : 40);
					seq_left--;
				end
				send(it, 1'b0, 1'b0, no_hit);
			end
		end

		// run one long sequence back to back, then start a fresh one
		settle();
		write_regs(6'd1, 21'sd0);
		in_idle_pct = 0;
		out_idle_pct = 0;
		sid = SEQ_ID_W'($urandom);
		send(scan_of(pick_symbol(), 1'b1, sid), 1'b0, 1'b0, no_hit);
		for (n = 0; n < TAIL_ITEMS; n++)
			send(scan_of(pick_symbol(), 1'b0, SEQ_ID_W'($urandom)), 1'b0, 1'b0, no_hit);
		send(scan_of(pick_symbol(), 1'b1, ~sid), 1'b0, 1'b0, no_hit);
		repeat (4) send(scan_of(pick_symbol(), 1'b0, SEQ_ID_W'($urandom)), 1'b0, 1'b0, no_hit);

		settle();
		if (pending_hits.size() != 0) begin
			$display("%0d expected hits never arrived", pending_hits.size());
			mismatches += pending_hits.size();
		end
		if (mismatches == 0)
			$display("pwm_window_scanner_unit_tb passed");
		else
			$display("pwm_window_scanner_unit_tb failed");
		$finish;
	end

endmodule
